### hdl/iso_dt_pkg.sv
// Shared types, constants and decode functions for the ISO 8601 basic
// date-time parser. No dependencies; used by iso_dt_core, the top level
// and the port checker.
package iso_dt_pkg;

    // Character positions inside a record
    localparam logic [4:0] SEP_POS = 5'd8;
    localparam logic [4:0] END_POS = 5'd15;

    // Characters of interest
    localparam logic [7:0] CHAR_ZERO = 8'h30;
    localparam logic [7:0] CHAR_NINE = 8'h39;
    localparam logic [7:0] CHAR_T    = 8'h54;
    localparam logic [7:0] CHAR_Z    = 8'h5A;

    // Range limits
    localparam logic [6:0] MONTH_MAX  = 7'd12;
    localparam logic [6:0] HOUR_LIM   = 7'd24;
    localparam logic [6:0] MINUTE_LIM = 7'd60;
    localparam logic [6:0] SECOND_MAX = 7'd60;

    // Consumed counts for a good record
    localparam logic [4:0] CONSUMED_PLAIN = 5'd15;
    localparam logic [4:0] CONSUMED_UTC   = 5'd16;

    // Result status codes
    typedef enum logic [3:0] {
        ST_OK            = 4'd0,
        ST_YEAR_DIGITS   = 4'd1,
        ST_MONTH_DIGITS  = 4'd2,
        ST_MONTH_RANGE   = 4'd3,
        ST_DAY_DIGITS    = 4'd4,
        ST_DAY_RANGE     = 4'd5,
        ST_MISSING_T     = 4'd6,
        ST_HOUR_DIGITS   = 4'd7,
        ST_HOUR_RANGE    = 4'd8,
        ST_MINUTE_DIGITS = 4'd9,
        ST_MINUTE_RANGE  = 4'd10,
        ST_SECOND_DIGITS = 4'd11,
        ST_SECOND_RANGE  = 4'd12
    } t_status;

    // One result word
    typedef struct packed {
        t_status     status;
        logic [13:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
        logic        is_utc;
        logic [4:0]  consumed;
    } t_result;

    // Field (digits status) that owns a character position
    function automatic t_status fld_code(input logic [4:0] pos);
        t_status code;
        unique case (pos)
            5'd0, 5'd1, 5'd2, 5'd3: code = ST_YEAR_DIGITS;
            5'd4, 5'd5:             code = ST_MONTH_DIGITS;
            5'd6, 5'd7:             code = ST_DAY_DIGITS;
            5'd8:                   code = ST_MISSING_T;
            5'd9, 5'd10:            code = ST_HOUR_DIGITS;
            5'd11, 5'd12:           code = ST_MINUTE_DIGITS;
            default:                code = ST_SECOND_DIGITS;
        endcase
        return code;
    endfunction

    // First position of the field that owns a position
    function automatic logic [4:0] fld_start(input logic [4:0] pos);
        logic [4:0] start;
        unique case (pos)
            5'd0, 5'd1, 5'd2, 5'd3: start = 5'd0;
            5'd4, 5'd5:             start = 5'd4;
            5'd6, 5'd7:             start = 5'd6;
            5'd8:                   start = 5'd8;
            5'd9, 5'd10:            start = 5'd9;
            5'd11, 5'd12:           start = 5'd11;
            default:                start = 5'd13;
        endcase
        return start;
    endfunction

    // Last position of the field that owns a position
    function automatic logic [4:0] fld_end(input logic [4:0] pos);
        logic [4:0] last_pos;
        unique case (pos)
            5'd0, 5'd1, 5'd2, 5'd3: last_pos = 5'd3;
            5'd4, 5'd5:             last_pos = 5'd5;
            5'd6, 5'd7:             last_pos = 5'd7;
            5'd8:                   last_pos = 5'd8;
            5'd9, 5'd10:            last_pos = 5'd10;
            5'd11, 5'd12:           last_pos = 5'd12;
            default:                last_pos = 5'd14;
        endcase
        return last_pos;
    endfunction

    // Days in a month (month already known to be 1..12)
    function automatic logic [4:0] month_days(input logic [3:0] month, input logic leap);
        logic [4:0] days;
        unique case (month)
            4'd2:                      days = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:   days = 5'd30;
            default:                   days = 5'd31;
        endcase
        return days;
    endfunction

    // Remainder by 25 of a value below 250: reciprocal multiply, then subtract
    function automatic logic [4:0] mod25(input logic [7:0] v);
        logic [13:0] prod;
        logic [7:0]  quo;
        logic [7:0]  rem;
        prod = 14'(v) * 14'd41;
        quo  = {4'b0, prod[13:10]};
        rem  = v - 8'(quo * 8'd25);
        return rem[4:0];
    endfunction

    // acc * 10 + d, truncated to 7 bits
    function automatic logic [6:0] acc10_7(input logic [6:0] acc, input logic [3:0] d);
        return {acc[3:0], 3'b0} + {acc[5:0], 1'b0} + {3'b0, d};
    endfunction

    // acc * 10 + d, truncated to 14 bits
    function automatic logic [13:0] acc10_14(input logic [13:0] acc, input logic [3:0] d);
        return {acc[10:0], 3'b0} + {acc[12:0], 1'b0} + {10'b0, d};
    endfunction

endpackage

### hdl/iso8601_basic_datetime_parser_top.sv
// ISO 8601 basic date-time parser:
//   Slave stream: one ASCII character per word in s_tdata[7:0], s_tlast marks
//   the final character of a record (YYYYMMDDTHHMMSS with optional Z).
//   Master stream: one result word per record, given at the first error or
//   when the record completes; characters after that are dropped up to and
//   including the word marked last.
// Throughput: one character per cycle while the receiver takes the results.
//   Each word goes through an input register, the combinational parse logic
//   and the result register.
// The parse state updates once per word, in the same cycle as the check.
// Reset (synchronous, active low) empties both registers and clears the parse
//   state; the next word starts a fresh record.
// When the receiver stalls, the held result stays on o_m_tdata; the input
//   register takes at most one more word if it is empty, and the slave side
//   then stalls until the result is taken.
// Depends on iso_dt_pkg and iso_dt_core.
module iso8601_basic_datetime_parser_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] text_char
    input  logic        i_s_tlast,   // is_last
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // [3:0] status, [17:4] year, [21:18] month, [26:22] day, [31:27] hour,
    // [37:32] minute, [43:38] second, [44] is_utc, [49:45] consumed, [55:50] zero
    output logic [55:0] o_m_tdata
);

    logic                r_in_valid;
    logic [7:0]          r_in_char;
    logic                r_in_last;
    logic                r_out_valid;
    iso_dt_pkg::t_result r_out;

    logic                advance;
    logic                step;
    logic                res_valid;
    iso_dt_pkg::t_result res;

    // Output register free or being drained this cycle
    assign advance    = !r_out_valid || i_m_tready;
    assign step       = r_in_valid && advance;
    assign o_s_tready = !r_in_valid || advance;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_s_tvalid && o_s_tready) begin
            r_in_valid <= 1'b1;
        end else if (step) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_tvalid && o_s_tready) begin
            r_in_char <= i_s_tdata;
            r_in_last <= i_s_tlast;
        end
    end

    iso_dt_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (step),
        .i_char      (r_in_char),
        .i_last      (r_in_last),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= step && res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= res;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {6'b0, r_out.consumed, r_out.is_utc, r_out.second, r_out.minute,
                         r_out.hour, r_out.day, r_out.month, r_out.year, r_out.status};

endmodule

### hdl/iso_dt_core.sv
// Parse state and combinational step logic for one character word.
// Depends on iso_dt_pkg for codes, position tables and arithmetic helpers.
module iso_dt_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_step,
    input  logic [7:0]          i_char,
    input  logic                i_last,
    output logic                o_res_valid,
    output iso_dt_pkg::t_result o_res
);

    logic [4:0]  r_pos,    n_pos;
    logic        r_closed, n_closed;
    logic [13:0] r_year,   n_year;
    logic [4:0]  r_ymod,   n_ymod;
    logic [6:0]  r_month,  n_month;
    logic [6:0]  r_day,    n_day;
    logic [6:0]  r_hour,   n_hour;
    logic [6:0]  r_minute, n_minute;
    logic [6:0]  r_second, n_second;

    logic                  is_digit;
    logic [3:0]            digit;
    iso_dt_pkg::t_status   code;
    iso_dt_pkg::t_status   err;
    logic                  leap;
    logic [4:0]            pos_inc;
    logic                  clr;
    logic                  close_after;
    logic [5:0]            sec_fold;

    // Hold state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= '0;
            r_closed <= 1'b0;
            r_year   <= '0;
            r_ymod   <= '0;
            r_month  <= '0;
            r_day    <= '0;
            r_hour   <= '0;
            r_minute <= '0;
            r_second <= '0;
        end else begin
            r_pos    <= n_pos;
            r_closed <= n_closed;
            r_year   <= n_year;
            r_ymod   <= n_ymod;
            r_month  <= n_month;
            r_day    <= n_day;
            r_hour   <= n_hour;
            r_minute <= n_minute;
            r_second <= n_second;
        end
    end

    // Step one character: accumulate, check ranges, form the result
    always_comb begin
        n_pos       = r_pos;
        n_closed    = r_closed;
        n_year      = r_year;
        n_ymod      = r_ymod;
        n_month     = r_month;
        n_day       = r_day;
        n_hour      = r_hour;
        n_minute    = r_minute;
        n_second    = r_second;
        o_res_valid = 1'b0;
        o_res       = '0;
        err         = iso_dt_pkg::ST_OK;
        clr         = 1'b0;
        close_after = 1'b0;
        sec_fold    = '0;

        is_digit = (i_char >= iso_dt_pkg::CHAR_ZERO) && (i_char <= iso_dt_pkg::CHAR_NINE);
        digit    = i_char[3:0];
        code     = iso_dt_pkg::fld_code(r_pos);
        pos_inc  = r_pos + 5'd1;
        // Gregorian leap rule from year bits and year mod 25
        leap = ((r_year[1:0] == 2'd0) && (r_ymod != 5'd0))
            || ((r_year[3:0] == 4'd0) && (r_ymod == 5'd0));

        if (i_step) begin
            if (r_closed) begin
                // Drop until the last word of the record
                if (i_last) begin
                    clr = 1'b1;
                end
            end else if (r_pos >= iso_dt_pkg::END_POS) begin
                // Character after the seconds: success, Z counted
                sec_fold = (r_second == iso_dt_pkg::SECOND_MAX) ? 6'd59 : r_second[5:0];
                o_res_valid    = 1'b1;
                o_res.status   = iso_dt_pkg::ST_OK;
                o_res.year     = r_year;
                o_res.month    = r_month[3:0];
                o_res.day      = r_day[4:0];
                o_res.hour     = r_hour[4:0];
                o_res.minute   = r_minute[5:0];
                o_res.second   = sec_fold;
                o_res.is_utc   = (i_char == iso_dt_pkg::CHAR_Z);
                o_res.consumed = (i_char == iso_dt_pkg::CHAR_Z) ?
                                 iso_dt_pkg::CONSUMED_UTC : iso_dt_pkg::CONSUMED_PLAIN;
                clr         = 1'b1;
                close_after = !i_last;
            end else begin
                if (r_pos == iso_dt_pkg::SEP_POS) begin
                    if (i_char != iso_dt_pkg::CHAR_T) begin
                        err = iso_dt_pkg::ST_MISSING_T;
                    end
                end else if (!is_digit) begin
                    err = code;
                end else begin
                    // Accumulate the digit into its field
                    case (code)
                        iso_dt_pkg::ST_YEAR_DIGITS: begin
                            n_year = iso_dt_pkg::acc10_14(r_year, digit);
                            n_ymod = iso_dt_pkg::mod25({r_ymod, 3'b0}
                                     + {2'b0, r_ymod, 1'b0} + {4'b0, digit});
                        end
                        iso_dt_pkg::ST_MONTH_DIGITS:  n_month  = iso_dt_pkg::acc10_7(r_month, digit);
                        iso_dt_pkg::ST_DAY_DIGITS:    n_day    = iso_dt_pkg::acc10_7(r_day, digit);
                        iso_dt_pkg::ST_HOUR_DIGITS:   n_hour   = iso_dt_pkg::acc10_7(r_hour, digit);
                        iso_dt_pkg::ST_MINUTE_DIGITS: n_minute = iso_dt_pkg::acc10_7(r_minute, digit);
                        default:                      n_second = iso_dt_pkg::acc10_7(r_second, digit);
                    endcase
                    // Range check on the field's last digit
                    if (r_pos == iso_dt_pkg::fld_end(r_pos)) begin
                        case (code)
                            iso_dt_pkg::ST_MONTH_DIGITS: begin
                                if (n_month == 7'd0 || n_month > iso_dt_pkg::MONTH_MAX) begin
                                    err = iso_dt_pkg::ST_MONTH_RANGE;
                                end
                            end
                            iso_dt_pkg::ST_DAY_DIGITS: begin
                                if (n_day == 7'd0 || n_day >
                                    {2'b0, iso_dt_pkg::month_days(r_month[3:0], leap)}) begin
                                    err = iso_dt_pkg::ST_DAY_RANGE;
                                end
                            end
                            iso_dt_pkg::ST_HOUR_DIGITS: begin
                                if (n_hour >= iso_dt_pkg::HOUR_LIM) begin
                                    err = iso_dt_pkg::ST_HOUR_RANGE;
                                end
                            end
                            iso_dt_pkg::ST_MINUTE_DIGITS: begin
                                if (n_minute >= iso_dt_pkg::MINUTE_LIM) begin
                                    err = iso_dt_pkg::ST_MINUTE_RANGE;
                                end
                            end
                            iso_dt_pkg::ST_SECOND_DIGITS: begin
                                if (n_second > iso_dt_pkg::SECOND_MAX) begin
                                    err = iso_dt_pkg::ST_SECOND_RANGE;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end

                if (err != iso_dt_pkg::ST_OK) begin
                    // First error closes the record
                    o_res_valid    = 1'b1;
                    o_res.status   = err;
                    o_res.consumed = iso_dt_pkg::fld_start(r_pos);
                    clr            = 1'b1;
                    close_after    = !i_last;
                end else begin
                    n_pos = pos_inc;
                    if (pos_inc == iso_dt_pkg::END_POS) begin
                        // Record ends right after the seconds
                        if (i_last) begin
                            sec_fold = (n_second == iso_dt_pkg::SECOND_MAX) ?
                                       6'd59 : n_second[5:0];
                            o_res_valid    = 1'b1;
                            o_res.status   = iso_dt_pkg::ST_OK;
                            o_res.year     = n_year;
                            o_res.month    = n_month[3:0];
                            o_res.day      = n_day[4:0];
                            o_res.hour     = n_hour[4:0];
                            o_res.minute   = n_minute[5:0];
                            o_res.second   = sec_fold;
                            o_res.is_utc   = 1'b0;
                            o_res.consumed = iso_dt_pkg::CONSUMED_PLAIN;
                            clr            = 1'b1;
                        end
                    end else if (i_last) begin
                        // Record ends early: report the field that owns the next position
                        o_res_valid    = 1'b1;
                        o_res.status   = iso_dt_pkg::fld_code(pos_inc);
                        o_res.consumed = iso_dt_pkg::fld_start(pos_inc);
                        clr            = 1'b1;
                    end
                end
            end
        end

        // Clear the record, optionally dropping until the last word
        if (clr) begin
            n_pos    = '0;
            n_year   = '0;
            n_ymod   = '0;
            n_month  = '0;
            n_day    = '0;
            n_hour   = '0;
            n_minute = '0;
            n_second = '0;
            n_closed = close_after;
        end
    end

endmodule

### hdl/iso_dt_checker.sv
// Port-level checks for the ISO 8601 basic date-time parser top level,
// bound to iso8601_basic_datetime_parser_top. Uses iso_dt_pkg constants.
module iso_dt_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_m_tvalid,
    input logic [55:0] o_m_tdata
);

    // Reset empties the result register
    assert property (@(posedge i_clk) !i_rst_n |=> !o_m_tvalid)
        else $error("result valid right after reset");

    // A good record consumed 15 or 16 characters, 16 only with Z
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tdata[3:0] == iso_dt_pkg::ST_OK) |->
        ((o_m_tdata[49:45] == iso_dt_pkg::CONSUMED_UTC && o_m_tdata[44])
         || (o_m_tdata[49:45] == iso_dt_pkg::CONSUMED_PLAIN && !o_m_tdata[44])))
        else $error("bad consumed count on good record");

    // An error result carries only status and position
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tdata[3:0] != iso_dt_pkg::ST_OK) |->
        (o_m_tdata[44:4] == '0 && o_m_tdata[49:45] < iso_dt_pkg::CONSUMED_PLAIN))
        else $error("error result carries date fields");

    // A good record has its fields in range
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tdata[3:0] == iso_dt_pkg::ST_OK) |->
        (o_m_tdata[21:18] != 4'd0 && o_m_tdata[21:18] <= 4'd12 && o_m_tdata[26:22] != 5'd0
         && o_m_tdata[31:27] < 5'd24 && o_m_tdata[37:32] < 6'd60
         && o_m_tdata[43:38] < 6'd60))
        else $error("good record field out of range");

    // Status code stays within the defined set, padding stays zero
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[3:0] <= iso_dt_pkg::ST_SECOND_RANGE
                        && o_m_tdata[55:50] == 6'd0))
        else $error("undefined status code or padding set");

endmodule

bind iso8601_basic_datetime_parser_top iso_dt_checker u_iso_dt_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_m_tvalid (o_m_tvalid),
    .o_m_tdata  (o_m_tdata)
);

### tb/tb_iso8601_basic_datetime_parser_top.sv
`timescale 1ns / 1ps
// Self-checking bench for iso8601_basic_datetime_parser_top: a character stream
// in, one parse result word per record out, checked against an internal parser.
// Depends on iso_dt_pkg and the RTL of the top level.
module tb_iso8601_basic_datetime_parser_top;

    localparam int CLK_HALF    = 6;
    localparam int RESET_LEN   = 11;
    localparam int TEXT_ITEMS  = 1350;
    localparam int DRAIN_LEN   = 20;
    localparam int CYCLE_LIMIT = 400000;
    localparam int REPORT_MAX  = 10;

    // Kinds of generated record
    typedef enum int {
        REC_GOOD,
        REC_RANGE,
        REC_CORRUPT,
        REC_SHORT,
        REC_NOISE
    } t_rec_kind;

    // Receiver stall patterns
    typedef enum int {
        RX_OPEN,
        RX_LIGHT,
        RX_PERIODIC,
        RX_HEAVY
    } t_rx_mode;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } t_text_word;

    typedef struct packed {
        iso_dt_pkg::t_status status;
        logic [13:0]         year;
        logic [3:0]          month;
        logic [4:0]          day;
        logic [4:0]          hour;
        logic [5:0]          minute;
        logic [5:0]          second;
        logic                is_utc;
        logic [4:0]          consumed;
    } t_parse_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [7:0]  i_s_tdata = 8'h00;   // [7:0] text_char
    logic        i_s_tlast = 1'b0;    // is_last
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    // [3:0] status, [17:4] year, [21:18] month, [26:22] day, [31:27] hour,
    // [37:32] minute, [43:38] second, [44] is_utc, [49:45] consumed, [55:50] zero
    logic [55:0] o_m_tdata;

    iso8601_basic_datetime_parser_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    always #(CLK_HALF) i_clk = ~i_clk;

    t_text_word    text_q[$];
    logic [7:0]    rec_buf[$];
    t_parse_result result_q[$];
    int            fail_cnt = 0;
    int            cycle_cnt = 0;

    // Parser state mirrored by the bench
    logic [4:0]  char_pos = '0;
    logic        rec_closed = 1'b0;
    logic [13:0] year_acc = '0;
    logic [6:0]  month_acc = '0;
    logic [6:0]  day_acc = '0;
    logic [6:0]  hour_acc = '0;
    logic [6:0]  minute_acc = '0;
    logic [6:0]  second_acc = '0;

    // Gregorian month length; zero for a month outside 1..12
    function automatic int month_len(input int unsigned y, input int unsigned m);
        bit leap;
        leap = ((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0;
        case (m)
            1, 3, 5, 7, 8, 10, 12: return 31;
            4, 6, 9, 11:           return 30;
            2:                     return leap ? 29 : 28;
            default:               return 0;
        endcase
    endfunction

    // Field owning a character position: digits status, first and last index
    task automatic field_info(input logic [4:0] pos, output iso_dt_pkg::t_status code,
                              output logic [4:0] first, output logic [4:0] stop);
        case (pos)
            5'd0, 5'd1, 5'd2, 5'd3: begin
                code = iso_dt_pkg::ST_YEAR_DIGITS;   first = 5'd0;  stop = 5'd3;
            end
            5'd4, 5'd5: begin
                code = iso_dt_pkg::ST_MONTH_DIGITS;  first = 5'd4;  stop = 5'd5;
            end
            5'd6, 5'd7: begin
                code = iso_dt_pkg::ST_DAY_DIGITS;    first = 5'd6;  stop = 5'd7;
            end
            5'd8: begin
                code = iso_dt_pkg::ST_MISSING_T;     first = 5'd8;  stop = 5'd8;
            end
            5'd9, 5'd10: begin
                code = iso_dt_pkg::ST_HOUR_DIGITS;   first = 5'd9;  stop = 5'd10;
            end
            5'd11, 5'd12: begin
                code = iso_dt_pkg::ST_MINUTE_DIGITS; first = 5'd11; stop = 5'd12;
            end
            default: begin
                code = iso_dt_pkg::ST_SECOND_DIGITS; first = 5'd13; stop = 5'd14;
            end
        endcase
    endtask

    task automatic clear_parse();
        char_pos   = '0;
        rec_closed = 1'b0;
        year_acc   = '0;
        month_acc  = '0;
        day_acc    = '0;
        hour_acc   = '0;
        minute_acc = '0;
        second_acc = '0;
    endtask

    // Clear the record; keep dropping words unless this one was the last
    task automatic close_record(input logic last);
        clear_parse();
        if (!last)
            rec_closed = 1'b1;
    endtask

    task automatic expect_error(input iso_dt_pkg::t_status code, input logic [4:0] pos);
        t_parse_result r;
        r          = '0;
        r.status   = code;
        r.consumed = pos;
        result_q.push_back(r);
    endtask

    task automatic expect_ok(input logic utc);
        t_parse_result r;
        r.status   = iso_dt_pkg::ST_OK;
        r.year     = year_acc;
        r.month    = month_acc[3:0];
        r.day      = day_acc[4:0];
        r.hour     = hour_acc[4:0];
        r.minute   = minute_acc[5:0];
        r.second   = (second_acc == 7'd60) ? 6'd59 : second_acc[5:0];
        r.is_utc   = utc;
        r.consumed = utc ? iso_dt_pkg::CONSUMED_UTC : iso_dt_pkg::CONSUMED_PLAIN;
        result_q.push_back(r);
    endtask

    // Advance the parse by one accepted character, queue any result it gives
    task automatic parse_char(input logic [7:0] ch, input logic last);
        iso_dt_pkg::t_status code;
        iso_dt_pkg::t_status err;
        logic [4:0]          first;
        logic [4:0]          stop;
        logic [3:0]          d;
        err = iso_dt_pkg::ST_OK;
        if (rec_closed) begin
            if (last)
                clear_parse();
            return;
        end
        // Seconds complete: this character only decides the zone
        if (char_pos >= iso_dt_pkg::END_POS) begin
            expect_ok(ch == iso_dt_pkg::CHAR_Z);
            close_record(last);
            return;
        end
        field_info(char_pos, code, first, stop);
        if (char_pos == iso_dt_pkg::SEP_POS) begin
            if (ch != iso_dt_pkg::CHAR_T)
                err = iso_dt_pkg::ST_MISSING_T;
        end else if (ch < iso_dt_pkg::CHAR_ZERO || ch > iso_dt_pkg::CHAR_NINE) begin
            err = code;
        end else begin
            d = 4'(ch - iso_dt_pkg::CHAR_ZERO);
            // Accumulators wrap at their own width
            case (code)
                iso_dt_pkg::ST_YEAR_DIGITS:   year_acc   = year_acc * 14'd10 + 14'(d);
                iso_dt_pkg::ST_MONTH_DIGITS:  month_acc  = month_acc * 7'd10 + 7'(d);
                iso_dt_pkg::ST_DAY_DIGITS:    day_acc    = day_acc * 7'd10 + 7'(d);
                iso_dt_pkg::ST_HOUR_DIGITS:   hour_acc   = hour_acc * 7'd10 + 7'(d);
                iso_dt_pkg::ST_MINUTE_DIGITS: minute_acc = minute_acc * 7'd10 + 7'(d);
                default:                      second_acc = second_acc * 7'd10 + 7'(d);
            endcase
            // Range check on the last digit of a field
            if (char_pos == stop) begin
                case (code)
                    iso_dt_pkg::ST_MONTH_DIGITS:
                        if (month_acc < 7'd1 || month_acc > 7'd12)
                            err = iso_dt_pkg::ST_MONTH_RANGE;
                    iso_dt_pkg::ST_DAY_DIGITS:
                        if (day_acc < 7'd1 || day_acc > month_len(year_acc, month_acc))
                            err = iso_dt_pkg::ST_DAY_RANGE;
                    iso_dt_pkg::ST_HOUR_DIGITS:
                        if (hour_acc >= 7'd24)
                            err = iso_dt_pkg::ST_HOUR_RANGE;
                    iso_dt_pkg::ST_MINUTE_DIGITS:
                        if (minute_acc >= 7'd60)
                            err = iso_dt_pkg::ST_MINUTE_RANGE;
                    iso_dt_pkg::ST_SECOND_DIGITS:
                        if (second_acc > 7'd60)
                            err = iso_dt_pkg::ST_SECOND_RANGE;
                    default: ;
                endcase
            end
        end
        if (err != iso_dt_pkg::ST_OK) begin
            expect_error(err, first);
            close_record(last);
            return;
        end
        char_pos = char_pos + 5'd1;
        if (char_pos >= iso_dt_pkg::END_POS) begin
            if (last) begin
                expect_ok(1'b0);
                clear_parse();
            end
            return;
        end
        // Record cut short: report the field that should come next
        if (last) begin
            field_info(char_pos, code, first, stop);
            expect_error(code, first);
            clear_parse();
        end
    endtask

    // Record building: fill rec_buf, then move it to the stream with tlast at its end
    task automatic push_digits(input int unsigned v, input int n);
        int unsigned div;
        div = 1;
        for (int i = 1; i < n; i++)
            div = div * 10;
        for (int i = 0; i < n; i++) begin
            rec_buf.push_back(8'(iso_dt_pkg::CHAR_ZERO + (v / div) % 10));
            div = div / 10;
        end
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++)
            rec_buf.push_back(s[i]);
    endtask

    task automatic commit_record();
        t_text_word w;
        for (int i = 0; i < rec_buf.size(); i++) begin
            w.ch   = rec_buf[i];
            w.last = (i == rec_buf.size() - 1);
            text_q.push_back(w);
        end
        rec_buf.delete();
    endtask

    function automatic logic [7:0] odd_char();
        logic [7:0] picks[6];
        picks = '{8'h2F, 8'h3A, iso_dt_pkg::CHAR_T, iso_dt_pkg::CHAR_Z, 8'h20, 8'hB0};
        if ($urandom_range(0, 1) == 0)
            return 8'($urandom_range(0, 255));
        return picks[$urandom_range(0, 5)];
    endfunction

    task automatic make_record(input t_rec_kind kind);
        int unsigned years[11];
        int unsigned y, mo, dy, hr, mi, se;
        int unsigned n;
        years = '{0, 4, 100, 400, 1900, 2000, 2024, 2100, 2400, 9996, 9999};
        if (kind == REC_NOISE) begin
            n = $urandom_range(1, 20);
            for (int i = 0; i < n; i++)
                rec_buf.push_back(($urandom_range(0, 2) == 0) ?
                    8'(iso_dt_pkg::CHAR_ZERO + $urandom_range(0, 9)) : odd_char());
            commit_record();
            return;
        end
        y  = ($urandom_range(0, 3) == 0) ? years[$urandom_range(0, 10)]
                                         : $urandom_range(0, 9999);
        mo = $urandom_range(1, 12);
        dy = ($urandom_range(0, 7) == 0) ? month_len(y, mo)
                                         : $urandom_range(1, month_len(y, mo));
        hr = $urandom_range(0, 23);
        mi = $urandom_range(0, 59);
        se = ($urandom_range(0, 7) == 0) ? 60 : $urandom_range(0, 59);
        // Push one field out of its range
        if (kind == REC_RANGE) begin
            case ($urandom_range(0, 4))
                0: mo = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(13, 99);
                1: dy = ($urandom_range(0, 1) == 0) ? 0
                                                    : $urandom_range(month_len(y, mo) + 1, 99);
                2: hr = $urandom_range(24, 99);
                3: mi = $urandom_range(60, 99);
                default: se = $urandom_range(61, 99);
            endcase
        end
        push_digits(y, 4);
        push_digits(mo, 2);
        push_digits(dy, 2);
        rec_buf.push_back(iso_dt_pkg::CHAR_T);
        push_digits(hr, 2);
        push_digits(mi, 2);
        push_digits(se, 2);
        // Optional zone and trailing characters
        case ($urandom_range(0, 4))
            0: ;
            1: rec_buf.push_back(iso_dt_pkg::CHAR_Z);
            2: begin
                rec_buf.push_back(iso_dt_pkg::CHAR_Z);
                n = $urandom_range(1, 4);
                for (int i = 0; i < n; i++)
                    rec_buf.push_back(odd_char());
            end
            3: rec_buf.push_back(odd_char());
            default: begin
                n = $urandom_range(1, 5);
                for (int i = 0; i < n; i++)
                    rec_buf.push_back(odd_char());
            end
        endcase
        if (kind == REC_CORRUPT)
            rec_buf[$urandom_range(0, rec_buf.size() - 1)] = odd_char();
        if (kind == REC_SHORT) begin
            n = $urandom_range(1, 15);
            while (rec_buf.size() > n)
                void'(rec_buf.pop_back());
        end
        commit_record();
    endtask

    function automatic string fmt_result(input t_parse_result r);
        return $sformatf("st=%0d y=%0d mo=%0d d=%0d h=%0d mi=%0d s=%0d z=%0d n=%0d",
                         r.status, r.year, r.month, r.day, r.hour, r.minute,
                         r.second, r.is_utc, r.consumed);
    endfunction

    always @(posedge i_clk)
        cycle_cnt <= cycle_cnt + 1;

    // Driver: send words from text_q in bursts with random gaps
    int         burst_left = 0;
    int         gap_left = 0;
    t_text_word send_word;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
            burst_left = 0;
            gap_left   = 0;
        end else begin
            if (i_s_tvalid && o_s_tready)
                parse_char(i_s_tdata, i_s_tlast);
            if (!i_s_tvalid || o_s_tready) begin
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 40);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end
                if (gap_left > 0) begin
                    gap_left--;
                    i_s_tvalid <= 1'b0;
                end else if (text_q.size() != 0) begin
                    send_word = text_q.pop_front();
                    i_s_tdata  <= send_word.ch;
                    i_s_tlast  <= send_word.last;
                    i_s_tvalid <= 1'b1;
                    burst_left--;
                end else begin
                    i_s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver: switch between random stall patterns
    t_rx_mode rx_mode = RX_OPEN;
    int       rx_left = 0;
    int       rx_phase = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else begin
            if (rx_left == 0) begin
                rx_mode = t_rx_mode'($urandom_range(0, 3));
                rx_left = $urandom_range(20, 150);
            end else begin
                rx_left--;
            end
            rx_phase = (rx_phase + 1) % 5;
            case (rx_mode)
                RX_OPEN:     i_m_tready <= 1'b1;
                RX_LIGHT:    i_m_tready <= ($urandom_range(0, 3) != 0);
                RX_PERIODIC: i_m_tready <= (rx_phase != 0);
                default:     i_m_tready <= ($urandom_range(0, 7) == 0);
            endcase
        end
    end

    // Monitor: compare each result word with the oldest expectation
    t_parse_result seen;
    t_parse_result want;

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            seen.status   = iso_dt_pkg::t_status'(o_m_tdata[3:0]);
            seen.year     = o_m_tdata[17:4];
            seen.month    = o_m_tdata[21:18];
            seen.day      = o_m_tdata[26:22];
            seen.hour     = o_m_tdata[31:27];
            seen.minute   = o_m_tdata[37:32];
            seen.second   = o_m_tdata[43:38];
            seen.is_utc   = o_m_tdata[44];
            seen.consumed = o_m_tdata[49:45];
            if (result_q.size() == 0) begin
                fail_cnt++;
                if (fail_cnt <= REPORT_MAX)
                    $display("%0t: unexpected result word: %s", $realtime, fmt_result(seen));
            end else begin
                want = result_q.pop_front();
                if (seen.status !== want.status || seen.year !== want.year ||
                    seen.month !== want.month || seen.day !== want.day ||
                    seen.hour !== want.hour || seen.minute !== want.minute ||
                    seen.second !== want.second || seen.is_utc !== want.is_utc ||
                    seen.consumed !== want.consumed || o_m_tdata[55:50] !== 6'd0) begin
                    fail_cnt++;
                    if (fail_cnt <= REPORT_MAX)
                        $display("%0t: mismatch: expected %s, got %s pad=%0h", $realtime,
                                 fmt_result(want), fmt_result(seen), o_m_tdata[55:50]);
                end
            end
        end
    end

    // Stimulus, reset, end of run
    initial begin
        // Leap day and leap second with zone, century rules (1900 has no Feb 29), extremes
        push_text("20240229T235960Z");  commit_record();
        push_text("19000229T000000");   commit_record();
        push_text("20000229T120000");   commit_record();
        push_text("99991231T235959X");  commit_record();
        push_text("00000101T000000Zab"); commit_record();
        // Digit errors of year, hour, minute and second, range errors, missing separator
        push_text("2a24");              commit_record();
        push_text("20241301T000000");   commit_record();
        push_text("20240001T000000");   commit_record();
        push_text("20240431T000000");   commit_record();
        push_text("20240101X000000");   commit_record();
        push_text("20240101T2x");       commit_record();
        push_text("20240101T240000");   commit_record();
        push_text("20240101T12:000");   commit_record();
        push_text("20240101T126000");   commit_record();
        push_text("20240101T12125/");   commit_record();
        push_text("20240101T121261");   commit_record();
        // Records cut short, before a field and before the separator
        push_text("2024");              commit_record();
        push_text("20240101");          commit_record();
        push_text("20240101T12");       commit_record();
        // Extreme byte values
        rec_buf.push_back(8'hFF);
        rec_buf.push_back(8'h00);
        commit_record();
        rec_buf.push_back(8'h00);
        commit_record();

        // Random records, well formed ones the most common kind
        while (text_q.size() < TEXT_ITEMS) begin
            case ($urandom_range(0, 19))
                0, 1, 2, 3, 4, 5, 6, 7, 8: make_record(REC_GOOD);
                9, 10, 11:                  make_record(REC_RANGE);
                12, 13, 14:                 make_record(REC_CORRUPT);
                15, 16, 17:                 make_record(REC_SHORT);
                default:                    make_record(REC_NOISE);
            endcase
        end

        repeat (RESET_LEN) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Wait for every word to be sent and every result to arrive
        while ((text_q.size() != 0 || i_s_tvalid || result_q.size() != 0) &&
               cycle_cnt < CYCLE_LIMIT)
            @(negedge i_clk);
        if (cycle_cnt < CYCLE_LIMIT)
            repeat (DRAIN_LEN) @(negedge i_clk);

        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_cnt, result_q.size());
            $display("Simulation FAILED");
        end else if (fail_cnt == 0 && result_q.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("%0d failures, %0d results never seen", fail_cnt, result_q.size());
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
